// ----- hdl/fmrq_pkg.sv -----
package fmrq_pkg;

    localparam int RING_BYTES = 4096;
    localparam int HDR_BYTES  = 27;
    localparam int MIN_RING   = 32;

    typedef enum logic [1:0] {
        CMD_ENQ  = 2'd0,
        CMD_PUSH = 2'd1,
        CMD_DEQ  = 2'd2,
        CMD_POP  = 2'd3
    } cmd_code_t;

    typedef enum logic [2:0] {
        STS_OK    = 3'd0,
        STS_FULL  = 3'd1,
        STS_EMPTY = 3'd2,
        STS_LONG  = 3'd3,
        STS_SEQ   = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        REG_RING_SIZE = 2'd0,
        REG_TIMEOUT   = 2'd1,
        REG_MAX_LEN   = 2'd2
    } reg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ENQ,
        ST_HWR,
        ST_DQ,
        ST_HRD,
        ST_HCAP,
        ST_CHECK,
        ST_POP1,
        ST_FIN
    } state_t;

    typedef enum logic [2:0] {
        FIN_ENQ,
        FIN_PUSH,
        FIN_DEQ,
        FIN_POP,
        FIN_SEQ,
        FIN_FULL,
        FIN_EMPTY,
        FIN_BAD
    } fin_t;

    typedef struct packed {
        logic take;
        logic hwr;
        logic hrd_start;
        logic hrd;
        logic skip;
        logic fin_go;
        fin_t fin;
    } fmrq_cmd_t;

    typedef struct packed {
        logic refuse;
        logic enq_open;
        logic deq_open;
        logic empty;
        logic hdr_last;
        logic bad;
        logic stale;
        logic out_free;
    } fmrq_stat_t;

endpackage

// ----- hdl/fmrq_ctrl.sv -----
module fmrq_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic [1:0]          s_command,
    output logic                s_ready,
    input  fmrq_pkg::fmrq_stat_t stat,
    output fmrq_pkg::fmrq_cmd_t  cmd
);

    fmrq_pkg::state_t state_reg, state_next;
    fmrq_pkg::fin_t   fin_reg, fin_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= fmrq_pkg::ST_IDLE;
            fin_reg   <= fmrq_pkg::FIN_SEQ;
        end else begin
            state_reg <= state_next;
            fin_reg   <= fin_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        fin_next      = fin_reg;
        cmd           = '0;
        cmd.fin       = fin_reg;
        s_ready       = (state_reg == fmrq_pkg::ST_IDLE);
        case (state_reg)
            fmrq_pkg::ST_IDLE: begin
                if (s_valid) begin
                    cmd.take = 1'b1;
                    case (fmrq_pkg::cmd_code_t'(s_command))
                        fmrq_pkg::CMD_ENQ: state_next = fmrq_pkg::ST_ENQ;
                        fmrq_pkg::CMD_PUSH: begin
                            fin_next   = stat.enq_open ? fmrq_pkg::FIN_PUSH
                                                       : fmrq_pkg::FIN_SEQ;
                            state_next = fmrq_pkg::ST_FIN;
                        end
                        fmrq_pkg::CMD_DEQ: state_next = fmrq_pkg::ST_DQ;
                        default: begin
                            if (stat.deq_open) begin
                                fin_next   = fmrq_pkg::FIN_POP;
                                state_next = fmrq_pkg::ST_POP1;
                            end else begin
                                fin_next   = fmrq_pkg::FIN_SEQ;
                                state_next = fmrq_pkg::ST_FIN;
                            end
                        end
                    endcase
                end
            end
            fmrq_pkg::ST_ENQ: begin
                if (stat.refuse) begin
                    fin_next   = fmrq_pkg::FIN_FULL;
                    state_next = fmrq_pkg::ST_FIN;
                end else begin
                    state_next = fmrq_pkg::ST_HWR;
                end
            end
            fmrq_pkg::ST_HWR: begin
                cmd.hwr = 1'b1;
                if (stat.hdr_last) begin
                    fin_next   = fmrq_pkg::FIN_ENQ;
                    state_next = fmrq_pkg::ST_FIN;
                end
            end
            fmrq_pkg::ST_DQ: begin
                if (stat.empty) begin
                    fin_next   = fmrq_pkg::FIN_EMPTY;
                    state_next = fmrq_pkg::ST_FIN;
                end else begin
                    cmd.hrd_start = 1'b1;
                    state_next    = fmrq_pkg::ST_HRD;
                end
            end
            fmrq_pkg::ST_HRD: begin
                cmd.hrd = 1'b1;
                if (stat.hdr_last) state_next = fmrq_pkg::ST_HCAP;
            end
            fmrq_pkg::ST_HCAP: state_next = fmrq_pkg::ST_CHECK;
            fmrq_pkg::ST_CHECK: begin
                if (stat.bad) begin
                    fin_next   = fmrq_pkg::FIN_BAD;
                    state_next = fmrq_pkg::ST_FIN;
                end else if (stat.stale) begin
                    cmd.skip   = 1'b1;
                    state_next = fmrq_pkg::ST_DQ;
                end else begin
                    fin_next   = fmrq_pkg::FIN_DEQ;
                    state_next = fmrq_pkg::ST_FIN;
                end
            end
            fmrq_pkg::ST_POP1: state_next = fmrq_pkg::ST_FIN;
            fmrq_pkg::ST_FIN: begin
                if (stat.out_free) begin
                    cmd.fin_go = 1'b1;
                    state_next = fmrq_pkg::ST_IDLE;
                end
            end
            default: state_next = fmrq_pkg::ST_IDLE;
        endcase
    end

endmodule

// ----- hdl/fmrq_dp.sv -----
module fmrq_dp (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [1:0]           cfg_index,
    input  logic [31:0]          cfg_wr_data,
    input  logic [1:0]           s_command,
    input  logic [31:0]          s_flow,
    input  logic [7:0]           s_msg_type,
    input  logic [12:0]          s_data_len,
    input  logic [12:0]          s_ext_len,
    input  logic [63:0]          s_time_now,
    input  logic [7:0]           s_data_byte,
    input  fmrq_pkg::fmrq_cmd_t  cmd,
    output fmrq_pkg::fmrq_stat_t stat,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [2:0]           m_status,
    output logic [31:0]          m_out_flow,
    output logic [7:0]           m_out_type,
    output logic [12:0]          m_out_data_len,
    output logic [12:0]          m_out_ext_len,
    output logic [63:0]          m_out_stamp,
    output logic [7:0]           m_out_byte,
    output logic                 m_last_byte
);

    logic [7:0] mem [fmrq_pkg::RING_BYTES];
    logic [7:0] mem_q;

    logic [12:0] ring_size_reg, max_len_reg;
    logic [31:0] timeout_reg;
    logic [11:0] head_reg, tail_reg, wr_idx_reg, rd_idx_reg, haddr_reg;
    logic [12:0] push_rem_reg, pop_rem_reg;
    logic        enq_open_reg, deq_open_reg;
    logic [31:0] flow_in_reg;
    logic [7:0]  type_in_reg, byte_in_reg;
    logic [12:0] dl_reg, el_reg;
    logic [63:0] time_reg;
    logic [4:0]  hk_reg, rd_k_reg;
    logic        rd_pend_reg;
    logic [63:0] h_stamp_reg;
    logic [31:0] h_total_reg, h_flow_reg;
    logic [7:0]  h_type_reg;
    logic [15:0] h_ext_reg;
    logic        m_valid_reg, m_last_reg;
    logic [2:0]  m_status_reg;
    logic [31:0] m_flow_reg;
    logic [7:0]  m_type_reg, m_byte_reg;
    logic [12:0] m_dl_reg, m_ext_reg;
    logic [63:0] m_stamp_reg;

    logic [12:0] ring_len, free_b, used_b;
    logic [14:0] enq_total;
    logic [63:0] age;
    logic [31:0] deq_dl;
    logic [11:0] raddr, wr_inc, rd_inc, hdr_ofs_tail, hdr_ofs_head, haddr_inc;
    logic [7:0]  hbyte;
    logic        wen;
    logic [11:0] waddr;
    logic [7:0]  wdata;
    logic [12:0] pop_total;

    function automatic logic [11:0] wrap_add(input logic [11:0] a, input logic [12:0] b,
                                             input logic [12:0] s);
        logic [13:0] sum;
        sum = {2'b00, a} + {1'b0, b};
        if (sum >= {1'b0, s}) sum = sum - {1'b0, s};
        return sum[11:0];
    endfunction

    always_comb begin
        if (ring_size_reg < 13'(fmrq_pkg::MIN_RING)) ring_len = 13'(fmrq_pkg::MIN_RING);
        else if (ring_size_reg > 13'(fmrq_pkg::RING_BYTES))
            ring_len = 13'(fmrq_pkg::RING_BYTES);
        else ring_len = ring_size_reg;
    end

    assign free_b = (head_reg > tail_reg) ? {1'b0, head_reg} - {1'b0, tail_reg}
                  : {1'b0, head_reg} + ring_len - {1'b0, tail_reg};
    assign used_b = (tail_reg > head_reg) ? {1'b0, tail_reg} - {1'b0, head_reg}
                  : {1'b0, tail_reg} + ring_len - {1'b0, head_reg};
    assign enq_total = 15'(fmrq_pkg::HDR_BYTES) + {2'b00, dl_reg} + {2'b00, el_reg};
    assign age = (time_reg >= h_stamp_reg) ? time_reg - h_stamp_reg : 64'd0;
    assign deq_dl = h_total_reg - 32'(fmrq_pkg::HDR_BYTES) - {16'd0, h_ext_reg};

    assign wr_inc       = wrap_add(wr_idx_reg, 13'd1, ring_len);
    assign rd_inc       = wrap_add(rd_idx_reg, 13'd1, ring_len);
    assign haddr_inc    = wrap_add(haddr_reg, 13'd1, ring_len);
    assign hdr_ofs_tail = wrap_add(tail_reg, 13'(fmrq_pkg::HDR_BYTES), ring_len);
    assign hdr_ofs_head = wrap_add(head_reg, 13'(fmrq_pkg::HDR_BYTES), ring_len);
    assign pop_total    = deq_dl[12:0] + h_ext_reg[12:0];

    // Header byte at offset hk: stamp, zero pad, total, flow, type, extension length.
    always_comb begin
        hbyte = 8'd0;
        if (hk_reg < 5'd8) hbyte = time_reg[{hk_reg[2:0], 3'b000} +: 8];
        else if (hk_reg >= 5'd16 && hk_reg < 5'd20)
            hbyte = 8'({17'd0, enq_total} >> {hk_reg[1:0], 3'b000});
        else if (hk_reg >= 5'd20 && hk_reg < 5'd24)
            hbyte = flow_in_reg[{hk_reg[1:0], 3'b000} +: 8];
        else if (hk_reg == 5'd24) hbyte = type_in_reg;
        else if (hk_reg == 5'd25) hbyte = el_reg[7:0];
        else if (hk_reg == 5'd26) hbyte = {3'b000, el_reg[12:8]};
    end

    assign wen   = cmd.hwr || (cmd.fin_go && cmd.fin == fmrq_pkg::FIN_PUSH);
    assign waddr = cmd.hwr ? haddr_reg : wr_idx_reg;
    assign wdata = cmd.hwr ? hbyte : byte_in_reg;
    assign raddr = cmd.hrd ? haddr_reg : rd_idx_reg;

    always_ff @(posedge aclk) begin
        if (wen) mem[waddr] <= wdata;
        mem_q <= mem[raddr];
    end

    assign stat.refuse   = {2'b00, free_b} <= enq_total;
    assign stat.enq_open = enq_open_reg;
    assign stat.deq_open = deq_open_reg;
    assign stat.empty    = head_reg == tail_reg;
    assign stat.hdr_last = hk_reg == 5'(fmrq_pkg::HDR_BYTES - 1);
    assign stat.bad      = (h_total_reg > {19'd0, used_b}) ||
                           (h_total_reg < 32'(fmrq_pkg::HDR_BYTES) + {16'd0, h_ext_reg});
    assign stat.stale    = (timeout_reg != 32'd0) && (age > {32'd0, timeout_reg});
    assign stat.out_free = !m_valid_reg || m_ready;

    // Input word latch and header walk.
    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            flow_in_reg <= s_flow;
            type_in_reg <= s_msg_type;
            dl_reg      <= s_data_len;
            el_reg      <= s_ext_len;
            time_reg    <= s_time_now;
            byte_in_reg <= s_data_byte;
            hk_reg      <= 5'd0;
            haddr_reg   <= tail_reg;
        end else if (cmd.hrd_start) begin
            hk_reg    <= 5'd0;
            haddr_reg <= head_reg;
        end else if (cmd.hwr || cmd.hrd) begin
            hk_reg    <= hk_reg + 5'd1;
            haddr_reg <= haddr_inc;
        end
        rd_k_reg <= hk_reg;
        if (rd_pend_reg) begin
            if (rd_k_reg < 5'd8) h_stamp_reg[{rd_k_reg[2:0], 3'b000} +: 8] <= mem_q;
            else if (rd_k_reg >= 5'd16 && rd_k_reg < 5'd20)
                h_total_reg[{rd_k_reg[1:0], 3'b000} +: 8] <= mem_q;
            else if (rd_k_reg >= 5'd20 && rd_k_reg < 5'd24)
                h_flow_reg[{rd_k_reg[1:0], 3'b000} +: 8] <= mem_q;
            else if (rd_k_reg == 5'd24) h_type_reg <= mem_q;
            else if (rd_k_reg == 5'd25) h_ext_reg[7:0] <= mem_q;
            else if (rd_k_reg == 5'd26) h_ext_reg[15:8] <= mem_q;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_pend_reg   <= 1'b0;
            ring_size_reg <= 13'(fmrq_pkg::RING_BYTES);
            timeout_reg   <= 32'd0;
            max_len_reg   <= 13'(fmrq_pkg::RING_BYTES);
            head_reg      <= '0;
            tail_reg      <= '0;
            wr_idx_reg    <= '0;
            rd_idx_reg    <= '0;
            push_rem_reg  <= '0;
            pop_rem_reg   <= '0;
            enq_open_reg  <= 1'b0;
            deq_open_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            rd_pend_reg <= cmd.hrd;
            if (cfg_wr_en) begin
                case (fmrq_pkg::reg_index_t'(cfg_index))
                    fmrq_pkg::REG_RING_SIZE: begin
                        ring_size_reg <= cfg_wr_data[12:0];
                        head_reg      <= '0;
                        tail_reg      <= '0;
                        wr_idx_reg    <= '0;
                        rd_idx_reg    <= '0;
                        push_rem_reg  <= '0;
                        pop_rem_reg   <= '0;
                        enq_open_reg  <= 1'b0;
                        deq_open_reg  <= 1'b0;
                    end
                    fmrq_pkg::REG_TIMEOUT: timeout_reg <= cfg_wr_data;
                    fmrq_pkg::REG_MAX_LEN: max_len_reg <= cfg_wr_data[12:0];
                    default: ;
                endcase
            end
            if (cmd.take) begin
                if (s_command == fmrq_pkg::CMD_ENQ) enq_open_reg <= 1'b0;
                if (s_command == fmrq_pkg::CMD_DEQ) deq_open_reg <= 1'b0;
            end
            if (cmd.skip) head_reg <= wrap_add(head_reg, h_total_reg[12:0], ring_len);
            if (cmd.fin_go) begin
                m_valid_reg <= 1'b1;
                case (cmd.fin)
                    fmrq_pkg::FIN_ENQ: begin
                        wr_idx_reg   <= hdr_ofs_tail;
                        push_rem_reg <= dl_reg + el_reg;
                        if (dl_reg + el_reg == 13'd0) tail_reg <= hdr_ofs_tail;
                        else enq_open_reg <= 1'b1;
                    end
                    fmrq_pkg::FIN_PUSH: begin
                        wr_idx_reg   <= wr_inc;
                        push_rem_reg <= push_rem_reg - 13'd1;
                        if (push_rem_reg == 13'd1) begin
                            tail_reg     <= wr_inc;
                            enq_open_reg <= 1'b0;
                        end
                    end
                    fmrq_pkg::FIN_DEQ: begin
                        if (deq_dl <= {19'd0, max_len_reg}) begin
                            rd_idx_reg  <= hdr_ofs_head;
                            pop_rem_reg <= pop_total;
                            if (pop_total == 13'd0) head_reg <= hdr_ofs_head;
                            else deq_open_reg <= 1'b1;
                        end
                    end
                    fmrq_pkg::FIN_POP: begin
                        rd_idx_reg  <= rd_inc;
                        pop_rem_reg <= pop_rem_reg - 13'd1;
                        if (pop_rem_reg == 13'd1) begin
                            head_reg     <= rd_inc;
                            deq_open_reg <= 1'b0;
                        end
                    end
                    fmrq_pkg::FIN_BAD: head_reg <= tail_reg;
                    default: ;
                endcase
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result word; every field a command does not name reads as zero.
    always_ff @(posedge aclk) begin
        if (cmd.fin_go) begin
            m_status_reg <= fmrq_pkg::STS_OK;
            m_flow_reg   <= '0;
            m_type_reg   <= '0;
            m_dl_reg     <= '0;
            m_ext_reg    <= '0;
            m_stamp_reg  <= '0;
            m_byte_reg   <= '0;
            m_last_reg   <= 1'b0;
            case (cmd.fin)
                fmrq_pkg::FIN_DEQ: begin
                    m_flow_reg  <= h_flow_reg;
                    m_type_reg  <= h_type_reg;
                    m_dl_reg    <= deq_dl[12:0];
                    m_ext_reg   <= h_ext_reg[12:0];
                    m_stamp_reg <= h_stamp_reg;
                    if (deq_dl > {19'd0, max_len_reg}) m_status_reg <= fmrq_pkg::STS_LONG;
                end
                fmrq_pkg::FIN_POP: begin
                    m_byte_reg <= mem_q;
                    m_last_reg <= pop_rem_reg == 13'd1;
                end
                fmrq_pkg::FIN_SEQ:   m_status_reg <= fmrq_pkg::STS_SEQ;
                fmrq_pkg::FIN_FULL:  m_status_reg <= fmrq_pkg::STS_FULL;
                fmrq_pkg::FIN_EMPTY: m_status_reg <= fmrq_pkg::STS_EMPTY;
                fmrq_pkg::FIN_BAD:   m_status_reg <= fmrq_pkg::STS_EMPTY;
                default: ;
            endcase
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_out_flow     = m_flow_reg;
    assign m_out_type     = m_type_reg;
    assign m_out_data_len = m_dl_reg;
    assign m_out_ext_len  = m_ext_reg;
    assign m_out_stamp    = m_stamp_reg;
    assign m_out_byte     = m_byte_reg;
    assign m_last_byte    = m_last_reg;

endmodule

// ----- hdl/framed_message_ring_queue_unit.sv -----
// Framed message ring queue over a 4096-byte single-port-write, registered-read ring.
// One word is taken at a time. An accepted begin_enqueue writes the 27 header bytes one
// per cycle; a refused one, push_byte and out-of-sequence words write no header, and
// pop_byte waits in ST_POP1 for the registered read. A begin_dequeue that is not empty
// reads the 27 header bytes, then captures and checks the header; each stale message
// found is discarded and the next header is read. A finished result that is not yet
// taken holds the block in its finishing state until the output register frees.
module framed_message_ring_queue_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [31:0] s_flow,
    input  logic [7:0]  s_msg_type,
    input  logic [12:0] s_data_len,
    input  logic [12:0] s_ext_len,
    input  logic [63:0] s_time_now,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [31:0] m_out_flow,
    output logic [7:0]  m_out_type,
    output logic [12:0] m_out_data_len,
    output logic [12:0] m_out_ext_len,
    output logic [63:0] m_out_stamp,
    output logic [7:0]  m_out_byte,
    output logic        m_last_byte
);

    fmrq_pkg::fmrq_cmd_t  cmd;
    fmrq_pkg::fmrq_stat_t stat;

    fmrq_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_command (s_command),
        .s_ready   (s_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    fmrq_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data),
        .s_command      (s_command),
        .s_flow         (s_flow),
        .s_msg_type     (s_msg_type),
        .s_data_len     (s_data_len),
        .s_ext_len      (s_ext_len),
        .s_time_now     (s_time_now),
        .s_data_byte    (s_data_byte),
        .cmd            (cmd),
        .stat           (stat),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_out_flow     (m_out_flow),
        .m_out_type     (m_out_type),
        .m_out_data_len (m_out_data_len),
        .m_out_ext_len  (m_out_ext_len),
        .m_out_stamp    (m_out_stamp),
        .m_out_byte     (m_out_byte),
        .m_last_byte    (m_last_byte)
    );

    // A word is worked on alone, so ready drops right after an accept.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while a word is in work");

    a_last_is_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last_byte |-> m_status == fmrq_pkg::STS_OK)
        else $error("last byte marked on a failed word");

    a_fail_no_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != fmrq_pkg::STS_OK |-> m_out_byte == 8'd0)
        else $error("payload byte on a failed word");

endmodule

// ----- tb/fmrq_checker.sv -----
`timescale 1ns / 1ps

module fmrq_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [31:0] s_flow,
    input  logic [7:0]  s_msg_type,
    input  logic [12:0] s_data_len,
    input  logic [12:0] s_ext_len,
    input  logic [63:0] s_time_now,
    input  logic [7:0]  s_data_byte,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [2:0]  m_status,
    input  logic [31:0] m_out_flow,
    input  logic [7:0]  m_out_type,
    input  logic [12:0] m_out_data_len,
    input  logic [12:0] m_out_ext_len,
    input  logic [63:0] m_out_stamp,
    input  logic [7:0]  m_out_byte,
    input  logic        m_last_byte,
    output int          errors,
    output int          pending,
    output int          push_left,
    output int          pop_left
);

    localparam int STAMP_AREA = fmrq_pkg::HDR_BYTES - 11;

    typedef struct {
        fmrq_pkg::status_t st;
        logic [31:0] flow;
        logic [7:0]  typ;
        logic [12:0] dlen;
        logic [12:0] elen;
        logic [63:0] stamp;
        logic [7:0]  dbyte;
        logic        last;
    } reply_t;

    reply_t      replies_due[$];
    logic [7:0]  ring_mem [fmrq_pkg::RING_BYTES];
    int unsigned head_idx, tail_idx, wr_idx, rd_idx, push_cnt, pop_cnt;
    bit          enq_open, deq_open;
    int unsigned ring_cfg, timeout_us, max_len;

    function automatic int unsigned ring_span();
        if (ring_cfg < fmrq_pkg::MIN_RING) return fmrq_pkg::MIN_RING;
        if (ring_cfg > fmrq_pkg::RING_BYTES) return fmrq_pkg::RING_BYTES;
        return ring_cfg;
    endfunction

    function automatic longint unsigned read_le(int unsigned base, int unsigned n);
        longint unsigned v;
        v = 0;
        for (int i = n; i > 0; i--)
            v = (v << 8) | ring_mem[(base + i - 1) % ring_span()];
        return v;
    endfunction

    function automatic void write_le(int unsigned base, int unsigned n, longint unsigned v);
        for (int i = 0; i < n; i++) begin
            ring_mem[(base + i) % ring_span()] = v[7:0];
            v = v >> 8;
        end
    endfunction

    function automatic void clear_queue();
        head_idx = 0; tail_idx = 0; wr_idx = 0; rd_idx = 0;
        push_cnt = 0; pop_cnt = 0; enq_open = 0; deq_open = 0;
    endfunction

    function automatic reply_t queue_step(fmrq_pkg::cmd_code_t cmd);
        reply_t r;
        int unsigned sz, total, room, used, ext, dl;
        longint unsigned stamp, age;
        sz = ring_span();
        r = '{st: fmrq_pkg::STS_OK, default: '0};
        case (cmd)
            fmrq_pkg::CMD_ENQ: begin
                total = fmrq_pkg::HDR_BYTES + s_data_len + s_ext_len;
                room = head_idx > tail_idx ? head_idx - tail_idx : head_idx + sz - tail_idx;
                enq_open = 0;
                if (room <= total) begin
                    r.st = fmrq_pkg::STS_FULL;
                end else begin
                    write_le(tail_idx, 8, s_time_now);
                    write_le(tail_idx + 8, STAMP_AREA - 8, 0);
                    write_le(tail_idx + STAMP_AREA, 4, total);
                    write_le(tail_idx + STAMP_AREA + 4, 4, s_flow);
                    write_le(tail_idx + STAMP_AREA + 8, 1, s_msg_type);
                    write_le(tail_idx + STAMP_AREA + 9, 2, s_ext_len);
                    wr_idx = (tail_idx + fmrq_pkg::HDR_BYTES) % sz;
                    push_cnt = s_data_len + s_ext_len;
                    if (push_cnt == 0) tail_idx = wr_idx;
                    else enq_open = 1;
                end
            end
            fmrq_pkg::CMD_PUSH: begin
                if (!enq_open) begin
                    r.st = fmrq_pkg::STS_SEQ;
                end else begin
                    ring_mem[wr_idx] = s_data_byte;
                    wr_idx = (wr_idx + 1) % sz;
                    push_cnt--;
                    if (push_cnt == 0) begin
                        tail_idx = wr_idx;
                        enq_open = 0;
                    end
                end
            end
            fmrq_pkg::CMD_DEQ: begin
                deq_open = 0;
                forever begin
                    if (head_idx == tail_idx) begin
                        r.st = fmrq_pkg::STS_EMPTY;
                        break;
                    end
                    used = tail_idx > head_idx ? tail_idx - head_idx
                                               : tail_idx + sz - head_idx;
                    stamp = read_le(head_idx, 8);
                    total = 32'(read_le(head_idx + STAMP_AREA, 4));
                    ext = 32'(read_le(head_idx + STAMP_AREA + 9, 2));
                    if (total > used || total < fmrq_pkg::HDR_BYTES + ext) begin
                        head_idx = tail_idx;
                        r.st = fmrq_pkg::STS_EMPTY;
                        break;
                    end
                    // A stamp ahead of the current time counts as age zero.
                    age = s_time_now >= stamp ? s_time_now - stamp : 0;
                    if (timeout_us != 0 && age > timeout_us) begin
                        head_idx = (head_idx + total) % sz;
                        continue;
                    end
                    dl = total - fmrq_pkg::HDR_BYTES - ext;
                    r.flow = 32'(read_le(head_idx + STAMP_AREA + 4, 4));
                    r.typ = 8'(read_le(head_idx + STAMP_AREA + 8, 1));
                    r.dlen = 13'(dl);
                    r.elen = 13'(ext);
                    r.stamp = stamp;
                    if (dl > max_len) begin
                        r.st = fmrq_pkg::STS_LONG;
                        break;
                    end
                    rd_idx = (head_idx + fmrq_pkg::HDR_BYTES) % sz;
                    pop_cnt = dl + ext;
                    if (pop_cnt == 0) head_idx = rd_idx;
                    else deq_open = 1;
                    break;
                end
            end
            default: begin
                if (!deq_open) begin
                    r.st = fmrq_pkg::STS_SEQ;
                end else begin
                    r.dbyte = ring_mem[rd_idx];
                    rd_idx = (rd_idx + 1) % sz;
                    pop_cnt--;
                    if (pop_cnt == 0) begin
                        head_idx = rd_idx;
                        deq_open = 0;
                        r.last = 1;
                    end
                end
            end
        endcase
        return r;
    endfunction

    always @(posedge aclk) begin
        reply_t want;
        if (!aresetn) begin
            replies_due.delete();
            clear_queue();
            ring_cfg = fmrq_pkg::RING_BYTES;
            timeout_us = 0;
            max_len = fmrq_pkg::RING_BYTES;
            errors = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (replies_due.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: unexpected result word, status %0d", $realtime, m_status);
                end else begin
                    want = replies_due.pop_front();
                    if (m_status != want.st || m_out_flow != want.flow
                            || m_out_type != want.typ || m_out_data_len != want.dlen
                            || m_out_ext_len != want.elen || m_out_stamp != want.stamp
                            || m_out_byte != want.dbyte || m_last_byte != want.last) begin
                        errors++;
                        if (errors <= 10)
                            $display({"%0t: mismatch exp st=%0d flow=%h type=%h dl=%0d ",
                                      "el=%0d stamp=%h byte=%h last=%b got st=%0d flow=%h ",
                                      "type=%h dl=%0d el=%0d stamp=%h byte=%h last=%b"},
                                     $realtime, want.st, want.flow, want.typ, want.dlen,
                                     want.elen, want.stamp, want.dbyte, want.last,
                                     m_status, m_out_flow, m_out_type, m_out_data_len,
                                     m_out_ext_len, m_out_stamp, m_out_byte, m_last_byte);
                    end
                end
            end
            if (cfg_wr_en) begin
                case (fmrq_pkg::reg_index_t'(cfg_index))
                    fmrq_pkg::REG_RING_SIZE: begin
                        ring_cfg = cfg_wr_data[12:0];
                        clear_queue();
                    end
                    fmrq_pkg::REG_TIMEOUT: timeout_us = cfg_wr_data;
                    fmrq_pkg::REG_MAX_LEN: max_len = cfg_wr_data[12:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                replies_due.push_back(queue_step(fmrq_pkg::cmd_code_t'(s_command)));
        end
        pending = replies_due.size();
        push_left = enq_open ? push_cnt : 0;
        pop_left = deq_open ? pop_cnt : 0;
    end

endmodule

// ----- tb/framed_message_ring_queue_unit_tb.sv -----
`timescale 1ns / 1ps

module framed_message_ring_queue_unit_tb;

    localparam int CYCLE_LIMIT = 3000000;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_wr_en = 0;
    logic [1:0]  cfg_index = fmrq_pkg::REG_RING_SIZE;
    logic [31:0] cfg_wr_data = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [1:0]  s_command = fmrq_pkg::CMD_ENQ;
    logic [31:0] s_flow = 0;
    logic [7:0]  s_msg_type = 0;
    logic [12:0] s_data_len = 0;
    logic [12:0] s_ext_len = 0;
    logic [63:0] s_time_now = 0;
    logic [7:0]  s_data_byte = 0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [2:0]  m_status;
    logic [31:0] m_out_flow;
    logic [7:0]  m_out_type;
    logic [12:0] m_out_data_len;
    logic [12:0] m_out_ext_len;
    logic [63:0] m_out_stamp;
    logic [7:0]  m_out_byte;
    logic        m_last_byte;

    int errors, pending, push_left, pop_left;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_req = 0;
    int cycles = 0;
    longint unsigned now_us = 1000;

    always #5 aclk = ~aclk;

    framed_message_ring_queue_unit dut (.*);

    fmrq_checker checker_i (.*);

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // The receiver; a long hold-off lets the block fill and stall its input.
    initial begin
        int held;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_ready = 0;
                held = 0;
                while (held < 400) begin
                    @(negedge aclk);
                    held++;
                end
                hold_req = 0;
            end else begin
                m_ready = $urandom_range(99) >= recv_stall_pct;
            end
        end
    end

    task automatic send_word(fmrq_pkg::cmd_code_t cmd, logic [31:0] flow, logic [7:0] typ,
                             logic [12:0] dl, logic [12:0] el, logic [63:0] t,
                             logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 0;
            @(negedge aclk);
        end
        s_valid = 1;
        s_command = cmd;
        s_flow = flow;
        s_msg_type = typ;
        s_data_len = dl;
        s_ext_len = el;
        s_time_now = t;
        s_data_byte = b;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic write_reg(fmrq_pkg::reg_index_t idx, logic [31:0] val);
        s_valid = 0;
        while (pending != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
        cfg_wr_en = 1;
        cfg_index = idx;
        cfg_wr_data = val;
        @(negedge aclk);
        cfg_wr_en = 0;
    endtask

    task automatic enqueue_msg(logic [12:0] dl, logic [12:0] el, logic [63:0] t, bit cut,
                               inout int sent);
        send_word(fmrq_pkg::CMD_ENQ, $urandom, $urandom, dl, el, t, $urandom);
        sent++;
        while (push_left > 0 && !(cut && $urandom_range(9) == 0)) begin
            send_word(fmrq_pkg::CMD_PUSH, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom);
            sent++;
        end
    endtask

    task automatic dequeue_msg(logic [63:0] t, bit cut, inout int sent);
        send_word(fmrq_pkg::CMD_DEQ, $urandom, $urandom, $urandom, $urandom, t, $urandom);
        sent++;
        while (pop_left > 0 && !(cut && $urandom_range(9) == 0)) begin
            send_word(fmrq_pkg::CMD_POP, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom);
            sent++;
        end
    endtask

    task automatic random_traffic(int count);
        int sent, pick;
        logic [12:0] dl, el;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(99);
            now_us += $urandom_range(3);
            if ($urandom_range(49) == 0) now_us -= $urandom_range(60);
            if ($urandom_range(19) == 0) begin
                dl = $urandom_range(60);
                el = $urandom_range(40);
            end else begin
                dl = $urandom_range(8);
                el = $urandom_range(4);
            end
            if (pick < 42) begin
                enqueue_msg(dl, el, now_us, 1, sent);
            end else if (pick < 84) begin
                dequeue_msg(now_us, 1, sent);
            end else begin
                send_word(fmrq_pkg::cmd_code_t'($urandom_range(3)), $urandom, $urandom,
                          $urandom_range(4096), $urandom_range(4096),
                          {$urandom, $urandom}, $urandom);
                sent++;
            end
        end
    endtask

    initial begin
        int n;
        n = 0;
        repeat (7) @(negedge aclk);
        aresetn = 1;

        // Directed: defaults after reset, no idling.
        send_word(fmrq_pkg::CMD_POP, 0, 0, 0, 0, 0, 0);
        send_word(fmrq_pkg::CMD_PUSH, 0, 0, 0, 0, 0, 8'hff);
        send_word(fmrq_pkg::CMD_DEQ, 0, 0, 0, 0, 0, 0);
        send_word(fmrq_pkg::CMD_ENQ, 32'hffffffff, 8'hff, 0, 0, 64'hffffffffffffffff, 0);
        send_word(fmrq_pkg::CMD_ENQ, 0, 0, 4096, 4096, 0, 0);
        send_word(fmrq_pkg::CMD_ENQ, 0, 0, 4096, 0, 0, 0);
        send_word(fmrq_pkg::CMD_ENQ, 32'h5a5a_a5a5, 8'h00, 2, 1, 0, 0);
        send_word(fmrq_pkg::CMD_PUSH, 0, 0, 0, 0, 0, 8'h00);
        send_word(fmrq_pkg::CMD_ENQ, 32'h1234_5678, 8'h81, 1, 1, 7, 0);
        send_word(fmrq_pkg::CMD_PUSH, 0, 0, 0, 0, 0, 8'hff);
        send_word(fmrq_pkg::CMD_PUSH, 0, 0, 0, 0, 0, 8'h00);
        send_word(fmrq_pkg::CMD_PUSH, 0, 0, 0, 0, 0, 8'h55);
        send_word(fmrq_pkg::CMD_DEQ, 0, 0, 0, 0, 64'hffffffffffffffff, 0);
        send_word(fmrq_pkg::CMD_DEQ, 0, 0, 0, 0, 0, 0);
        send_word(fmrq_pkg::CMD_POP, 0, 0, 0, 0, 0, 0);
        send_word(fmrq_pkg::CMD_POP, 0, 0, 0, 0, 0, 0);
        send_word(fmrq_pkg::CMD_POP, 0, 0, 0, 0, 0, 0);
        send_word(fmrq_pkg::CMD_DEQ, 0, 0, 0, 0, 0, 0);
        random_traffic(80);

        // Smallest ring, widest timeout, no main payload accepted.
        write_reg(fmrq_pkg::REG_RING_SIZE, 32);
        write_reg(fmrq_pkg::REG_RING_SIZE, 5);
        write_reg(fmrq_pkg::REG_TIMEOUT, 32'hffffffff);
        write_reg(fmrq_pkg::REG_MAX_LEN, 0);
        send_idle_pct = 88;
        enqueue_msg(2, 0, now_us, 0, n);
        dequeue_msg(now_us, 0, n);
        enqueue_msg(0, 2, now_us, 0, n);
        dequeue_msg(now_us, 0, n);
        random_traffic(80);

        // Short timeout, stale and future stamps, receiver held off.
        send_idle_pct = 0;
        write_reg(fmrq_pkg::REG_RING_SIZE, 100);
        write_reg(fmrq_pkg::REG_TIMEOUT, 30);
        write_reg(fmrq_pkg::REG_MAX_LEN, 10);
        recv_stall_pct = 88;
        enqueue_msg(1, 0, now_us + 500, 0, n);
        dequeue_msg(now_us, 0, n);
        enqueue_msg(1, 1, now_us, 0, n);
        enqueue_msg(0, 0, now_us + 10, 0, n);
        now_us += 100;
        dequeue_msg(now_us, 0, n);
        hold_req = 1;
        random_traffic(80);

        // Oversized ring value saturates to the full ring.
        write_reg(fmrq_pkg::REG_RING_SIZE, 8191);
        write_reg(fmrq_pkg::REG_TIMEOUT, 0);
        write_reg(fmrq_pkg::REG_MAX_LEN, 8191);
        send_idle_pct = 28;
        recv_stall_pct = 28;
        random_traffic(80);
        write_reg(fmrq_pkg::REG_MAX_LEN, 4096);
        random_traffic(30);

        s_valid = 0;
        while (pending != 0) @(negedge aclk);
        repeat (50) @(negedge aclk);
        if (errors == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
